[hdl/two_level_priority_queue_assert.svh]
// assertion macros for the two-level priority queue
`ifndef TWO_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define TWO_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

// condition holds at every edge outside reset
`define TLPQ_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge gives the consequent at the next
`define TLPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tlpq_pkg.sv]
`default_nettype none
package tlpq_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned OCC_W       = 5;
  localparam logic signed [VALUE_W-1:0] THRESHOLD_RESET = 32'sd60;

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_PRIORITY = 2'd1,
    CMD_POP      = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    op_t                        op;
    logic                       high_mode;
    logic signed [VALUE_W-1:0]  value;
    logic signed [VALUE_W-1:0]  threshold;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hdl/tlpq_cmd_if.sv]
`default_nettype none
interface tlpq_cmd_if
  import tlpq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  cmd_t                      cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface
`default_nettype wire

[hdl/tlpq_res_if.sv]
`default_nettype none
interface tlpq_res_if
  import tlpq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_valid;
  status_t                   status;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output out_value, output out_valid, output status,
                  output occupancy, input ready);
  modport sink (input valid, input out_value, input out_valid, input status,
                input occupancy, output ready);
endinterface
`default_nettype wire

[hdl/tlpq_cfg_if.sv]
`default_nettype none
interface tlpq_cfg_if
  import tlpq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/tlpq_cell.sv]
`default_nettype none
module tlpq_cell
  import tlpq_pkg::*;
(
  input  wire logic                      clk,
  input  wire cell_ctrl_t                ctrl,
  input  wire logic                      occ,
  input  wire logic                      seek_in,
  output logic                           seek_out,
  input  wire logic signed [VALUE_W-1:0] left_entry,
  input  wire logic signed [VALUE_W-1:0] right_entry,
  output logic signed [VALUE_W-1:0]      entry
);

  logic                      hi;
  logic                      stop;
  logic                      point;
  logic signed [VALUE_W-1:0] entry_next;

  // a high-mode priority insert stops at the first cell that is not high, any other insert at the first free one
  assign hi       = occ && (entry >= ctrl.threshold);
  assign stop     = ctrl.high_mode ? !hi : !occ;
  assign point    = seek_in && stop;
  assign seek_out = seek_in && !stop;

  always_comb begin
    entry_next = entry;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (point) begin
          entry_next = ctrl.value;
        end else if (!seek_in) begin
          entry_next = left_entry;
        end
      end
      OP_POP: begin
        entry_next = right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

[hdl/two_level_priority_queue.sv]
// two-level priority queue of signed 32-bit values, QUEUE_DEPTH entries deep
// req channel: one word per command (cmd, value); cmd append, priority insert
// or pop head. rsp channel: one word per command (out_value, out_valid,
// status, occupancy). cfg channel: one word writes the priority threshold, always
// ready; write it only while no command is outstanding.
// the result word is registered and shown in the cycle after its command is taken.
// throughput: one command per cycle while rsp is not stalled; the contents sit in a row of cells and
// the insert point ripples along the row through each cell's seek flag in
// the same cycle that every cell shifts or loads.
// a waiting result word is held in the output register; req.ready stays high
// while that word is taken in the same cycle, so a stall on rsp stalls req
// after one word.
// reset (rst, synchronous): queue empty, no result pending, threshold 60.
// entry contents are not cleared; cells above the count are never read.
`default_nettype none
module two_level_priority_queue
  import tlpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tlpq_cmd_if.sink  req,
  tlpq_res_if.source rsp,
  tlpq_cfg_if.sink  cfg
);

`include "two_level_priority_queue_assert.svh"

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [VALUE_W-1:0] threshold;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      res_valid;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_popped;
  status_t                   res_status;
  logic [OCC_W-1:0]          res_occ;

  logic                      acc;
  logic                      is_insert;
  logic                      is_pop;
  logic                      full;
  logic                      empty;
  cell_ctrl_t                ctrl;
  status_t                   status_next;

  logic signed [VALUE_W-1:0] ent [QUEUE_DEPTH];
  logic                      seek [QUEUE_DEPTH+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.data;
    end
  end

  assign acc       = req.valid && req.ready;
  assign is_insert = (req.cmd == CMD_APPEND) || (req.cmd == CMD_PRIORITY);
  assign is_pop    = (req.cmd == CMD_POP);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    ctrl.op        = OP_HOLD;
    ctrl.high_mode = (req.cmd == CMD_PRIORITY) && (req.value >= threshold);
    ctrl.value     = req.value;
    ctrl.threshold = threshold;
    count_next     = count;
    status_next    = ST_OK;
    if (acc && is_insert) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        ctrl.op    = OP_INSERT;
        count_next = count + CNT_W'(1);
      end
    end else if (acc && is_pop) begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        ctrl.op    = OP_POP;
        count_next = count - CNT_W'(1);
      end
    end
  end

  assign seek[0] = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                      occ;
    logic signed [VALUE_W-1:0] left_entry;
    logic signed [VALUE_W-1:0] right_entry;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_entry = req.value;
    end else begin : g_mid
      assign left_entry = ent[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = ent[i];
    end else begin : g_body
      assign right_entry = ent[i+1];
    end

    tlpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .seek_in     (seek[i]),
      .seek_out    (seek[i+1]),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (acc) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_popped <= (ctrl.op == OP_POP);
      res_value  <= (ctrl.op == OP_POP) ? ent[0] : '0;
      res_status <= status_next;
      res_occ    <= OCC_W'(count_next);
    end
  end

  assign req.ready     = !res_valid || rsp.ready;
  assign rsp.valid     = res_valid;
  assign rsp.out_value = res_value;
  assign rsp.out_valid = res_popped;
  assign rsp.status    = res_status;
  assign rsp.occupancy = res_occ;

  `TLPQ_ASSERT_NOW(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "count beyond depth")
  `TLPQ_ASSERT_NEXT(a_pop_dec, ctrl.op == OP_POP, count == $past(count) - CNT_W'(1), "no decrement")
  `TLPQ_ASSERT_NEXT(a_full_hold, acc && is_insert && full, count == $past(count), "count moved")
  `TLPQ_ASSERT_NOW(a_pop_ok, !res_valid || !res_popped || res_status == ST_OK, "pop with error")

endmodule
`default_nettype wire
